>>> design/aes_pkg.sv
// Shared types, constants and round functions for the AES-128 encryption block.
package aes_pkg;

  typedef logic [127:0] blk_t;

  localparam int unsigned NumRounds = 10;
  localparam logic [0:0] CfgKeyLow  = 1'b0;
  localparam logic [0:0] CfgKeyHigh = 1'b1;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};

  localparam logic [7:0] RCON [NumRounds] = '{
    8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36};

  function automatic logic [7:0] xtime(input logic [7:0] v);
    xtime = {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic blk_t next_key(input blk_t p, input logic [7:0] rc);
    logic [31:0] t;
    blk_t k;
    t = {SBOX[p[103:96]], SBOX[p[127:120]], SBOX[p[119:112]], SBOX[p[111:104]] ^ rc};
    k[31:0] = p[31:0] ^ t;
    for (int w = 1; w < 4; w++) begin
      k[32*w +: 32] = k[32*(w-1) +: 32] ^ p[32*w +: 32];
    end
    next_key = k;
  endfunction

  function automatic blk_t enc_round(input blk_t s, input logic last);
    blk_t sh;
    blk_t o;
    logic [7:0] a0, a1, a2, a3, al;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        sh[8*(4*c+r) +: 8] = SBOX[s[8*(4*((c+r)%4)+r) +: 8]];
      end
    end
    for (int c = 0; c < 4; c++) begin
      a0 = sh[32*c +: 8];
      a1 = sh[32*c+8 +: 8];
      a2 = sh[32*c+16 +: 8];
      a3 = sh[32*c+24 +: 8];
      al = a0 ^ a1 ^ a2 ^ a3;
      o[32*c +: 8]    = a0 ^ al ^ xtime(a0 ^ a1);
      o[32*c+8 +: 8]  = a1 ^ al ^ xtime(a1 ^ a2);
      o[32*c+16 +: 8] = a2 ^ al ^ xtime(a2 ^ a3);
      o[32*c+24 +: 8] = a3 ^ al ^ xtime(a3 ^ a0);
    end
    enc_round = last ? sh : o;
  endfunction

endpackage

>>> design/aes_key_exp.sv
// Key register loaded through the configuration port.
module aes_key_exp (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [0:0]           cfg_idx,
  input  logic [63:0]          cfg_wdata,
  output aes_pkg::blk_t        cur_key
);
  import aes_pkg::*;

  blk_t key_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CfgKeyLow:  key_r[63:0]   <= cfg_wdata;
        CfgKeyHigh: key_r[127:64] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign cur_key = key_r;
endmodule

>>> design/aes_round_stage.sv
// One pipelined cipher round with its round key expansion, valid and stall control.
module aes_round_stage (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          last,
  input  logic          adv,
  input  logic [7:0]    rc,
  input  logic          in_v,
  input  aes_pkg::blk_t in_d,
  input  aes_pkg::blk_t in_k,
  output logic          out_v,
  output aes_pkg::blk_t out_d,
  output aes_pkg::blk_t out_k
);
  import aes_pkg::*;

  logic v_r;
  blk_t d_r;
  blk_t k_r;
  blk_t k_nxt;

  assign k_nxt = next_key(in_k, rc);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (adv) begin
      v_r <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d_r <= enc_round(in_d, last) ^ k_nxt;
      k_r <= k_nxt;
    end
  end

  assign out_v = v_r;
  assign out_d = d_r;
  assign out_k = k_r;
endmodule

>>> design/aes128_block_encrypt_top.sv
// Top level of the pipelined AES-128 block encryption.
// One item is accepted each cycle unless the pipeline holds; its ciphertext passes through
// an initial key-add stage and ten round stages, one register stage per round. The whole
// pipeline holds while a finished item waits at the output. The key is captured with each
// item and expanded alongside it, so a key write applies at once to the next item sent.
module aes128_block_encrypt_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_idx,
  input  logic [63:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] in_plain_low,
  input  logic [63:0] in_plain_high,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_cipher_low,
  output logic [63:0] out_cipher_high
);
  import aes_pkg::*;

  blk_t cur_key;
  logic v  [NumRounds+1];
  blk_t d  [NumRounds+1];
  blk_t k  [NumRounds+1];
  logic adv;
  logic v0_r;
  blk_t d0_r;
  blk_t k0_r;

  aes_key_exp u_key (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_idx(cfg_idx),
    .cfg_wdata(cfg_wdata), .cur_key(cur_key)
  );

  assign adv = out_ready || !v[NumRounds];
  assign in_ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (adv) begin
      v0_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d0_r <= {in_plain_high, in_plain_low} ^ cur_key;
      k0_r <= cur_key;
    end
  end

  assign v[0] = v0_r;
  assign d[0] = d0_r;
  assign k[0] = k0_r;

  for (genvar g = 1; g <= NumRounds; g++) begin : g_rnd
    aes_round_stage u_rnd (
      .clk(clk), .rst_n(rst_n), .last(g == NumRounds), .adv(adv), .rc(RCON[g-1]),
      .in_v(v[g-1]), .in_d(d[g-1]), .in_k(k[g-1]),
      .out_v(v[g]), .out_d(d[g]), .out_k(k[g])
    );
  end

  assign out_valid       = v[NumRounds];
  assign out_cipher_low  = d[NumRounds][63:0];
  assign out_cipher_high = d[NumRounds][127:64];
endmodule

>>> tb/sv/tb_top.sv
// Testbench for the pipelined AES-128 block encryption: random and known-answer blocks.
`timescale 1ns / 1ps

module tb_top;
  import aes_pkg::*;

  localparam int unsigned Latency   = 12;
  localparam int unsigned StallCap  = 2000;

  class cipher_board;
    logic [63:0] key_lo;
    logic [63:0] key_hi;
    blk_t        cipher_q[$];
    int          mismatches;

    function new();
      key_lo = '0;
      key_hi = '0;
      mismatches = 0;
    endfunction

    function automatic logic [7:0] dbl(logic [7:0] v);
      return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic blk_t encipher(blk_t pt);
      logic [7:0] rk[11][16];
      logic [7:0] st[16];
      logic [7:0] sh[16];
      logic [7:0] t[4];
      logic [7:0] a0, a1, a2, a3, al;
      blk_t       kb;
      blk_t       res;
      kb = {key_hi, key_lo};
      for (int j = 0; j < 16; j++) begin
        rk[0][j] = kb[8*j +: 8];
        st[j]    = pt[8*j +: 8] ^ rk[0][j];
      end
      for (int i = 1; i <= 10; i++) begin
        t[0] = SBOX[rk[i-1][13]] ^ RCON[i-1];
        t[1] = SBOX[rk[i-1][14]];
        t[2] = SBOX[rk[i-1][15]];
        t[3] = SBOX[rk[i-1][12]];
        for (int j = 0; j < 4; j++) rk[i][j] = rk[i-1][j] ^ t[j];
        for (int w = 1; w < 4; w++)
          for (int j = 0; j < 4; j++) rk[i][4*w+j] = rk[i][4*(w-1)+j] ^ rk[i-1][4*w+j];
      end
      for (int r = 1; r <= 10; r++) begin
        for (int c = 0; c < 4; c++)
          for (int w = 0; w < 4; w++) sh[4*c+w] = SBOX[st[4*((c+w)%4)+w]];
        for (int c = 0; c < 4; c++) begin
          a0 = sh[4*c];
          a1 = sh[4*c+1];
          a2 = sh[4*c+2];
          a3 = sh[4*c+3];
          al = a0 ^ a1 ^ a2 ^ a3;
          if (r != 10) begin
            st[4*c]   = a0 ^ al ^ dbl(a0 ^ a1);
            st[4*c+1] = a1 ^ al ^ dbl(a1 ^ a2);
            st[4*c+2] = a2 ^ al ^ dbl(a2 ^ a3);
            st[4*c+3] = a3 ^ al ^ dbl(a3 ^ a0);
          end else begin
            for (int w = 0; w < 4; w++) st[4*c+w] = sh[4*c+w];
          end
        end
        for (int j = 0; j < 16; j++) st[j] = st[j] ^ rk[r][j];
      end
      for (int j = 0; j < 16; j++) res[8*j +: 8] = st[j];
      return res;
    endfunction

    function void note_plain(logic [63:0] lo, logic [63:0] hi);
      cipher_q.push_back(encipher({hi, lo}));
    endfunction

    function void check_cipher(logic [63:0] lo, logic [63:0] hi);
      blk_t want;
      if (cipher_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected item: %h %h", hi, lo);
        return;
      end
      want = cipher_q.pop_front();
      if (want[63:0] !== lo || want[127:64] !== hi) begin
        mismatches++;
        if (mismatches <= 10)
          $display("cipher mismatch: want hi %h lo %h, got hi %h lo %h",
                   want[127:64], want[63:0], hi, lo);
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic        cfg_idx;
  logic [63:0] cfg_wdata;
  logic        in_valid;
  logic        in_ready;
  logic [63:0] in_plain_low;
  logic [63:0] in_plain_high;
  logic        out_valid;
  logic        out_ready;
  logic [63:0] out_cipher_low;
  logic [63:0] out_cipher_high;

  cipher_board board;
  bit          gaps_on = 1'b1;
  int unsigned quiet_cycles = 0;

  aes128_block_encrypt_top dut (.*);

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) board.note_plain(in_plain_low, in_plain_high);
      if (out_valid && out_ready) board.check_cipher(out_cipher_low, out_cipher_high);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= StallCap) begin
        $display("** aes128_block_encrypt_top: FAILED **");
        $finish;
      end
    end
  end

  // receiver: random stall bursts while gaps are enabled
  initial begin
    out_ready = 1'b0;
    @(posedge clk);
    forever begin
      if (gaps_on && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 24)) @(posedge clk);
    end
  end

  task automatic send_block(logic [63:0] lo, logic [63:0] hi);
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_plain_low <= lo;
    in_plain_high <= hi;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (board.cipher_q.size() != 0);
    repeat (Latency) @(posedge clk);
  endtask

  task automatic load_key(logic [63:0] lo, logic [63:0] hi);
    cfg_we <= 1'b1;
    cfg_idx <= CfgKeyLow;
    cfg_wdata <= lo;
    @(posedge clk);
    cfg_idx <= CfgKeyHigh;
    cfg_wdata <= hi;
    @(posedge clk);
    cfg_we <= 1'b0;
    board.key_lo = lo;
    board.key_hi = hi;
  endtask

  task automatic random_blocks(int unsigned n);
    repeat (n) send_block({$urandom, $urandom}, {$urandom, $urandom});
  endtask

  initial begin
    board = new();
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = CfgKeyLow;
    cfg_wdata = '0;
    in_valid = 1'b0;
    in_plain_low = '0;
    in_plain_high = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset key of zero
    send_block('0, '0);
    send_block('1, '1);
    for (int b = 0; b < 128; b += 17) begin
      blk_t p;
      p = blk_t'(1) << b;
      send_block(p[63:0], p[127:64]);
    end
    drain();

    load_key(64'h0706050403020100, 64'h0f0e0d0c0b0a0908);
    send_block(64'h7766554433221100, 64'hffeeddccbbaa9988);
    send_block('0, '1);
    send_block('1, '0);
    drain();

    load_key('1, '1);
    send_block('0, '0);
    send_block('1, '1);
    random_blocks(400);
    drain();

    load_key('0, '1);
    random_blocks(400);
    drain();

    load_key({$urandom, $urandom}, {$urandom, $urandom});
    random_blocks(400);
    drain();

    load_key({$urandom, $urandom}, {$urandom, $urandom});
    random_blocks(200);
    gaps_on = 1'b0;
    random_blocks(200);
    drain();

    if (board.mismatches == 0 && board.cipher_q.size() == 0) begin
      $display("** aes128_block_encrypt_top: PASSED **");
    end else begin
      $display("** aes128_block_encrypt_top: FAILED **");
    end
    $finish;
  end

endmodule

>>> aes128_block_encrypt_top.f
design/aes_pkg.sv
design/aes_key_exp.sv
design/aes_round_stage.sv
design/aes128_block_encrypt_top.sv
tb/sv/tb_top.sv
